// ===== hdl/lcpm_pkg.sv =====
// lcpm_pkg: shared types, constants and command codes for the LED cube plane
// multiplexer. No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lcpm_pkg;

    localparam int CUBE_SIDE  = 5;
    localparam int PLANE_BITS = CUBE_SIDE * CUBE_SIDE;
    localparam int FRAME_BITS = 32;
    localparam int PAD_BITS   = FRAME_BITS - PLANE_BITS - CUBE_SIDE;
    localparam int ALIGN_BITS = FRAME_BITS - PLANE_BITS;
    localparam int COORD_W    = 3;
    localparam int LINES_W    = 5;
    localparam int Z_W        = $clog2(CUBE_SIDE);
    localparam int POS_W      = $clog2(PLANE_BITS);
    localparam int CNT_W      = $clog2(FRAME_BITS);

    localparam logic [COORD_W-1:0] FUNC_CLEAR = 3'd0;
    localparam logic [COORD_W-1:0] FUNC_WRITE = 3'd1;
    localparam logic [COORD_W-1:0] FUNC_FILL  = 3'd2;
    localparam logic [COORD_W-1:0] FUNC_SHOW  = 3'd3;
    localparam logic [COORD_W-1:0] FUNC_NEXT  = 3'd4;

    typedef struct packed {
        logic [2:0] func;
        logic [2:0] x_row;
        logic [2:0] y_col;
        logic [2:0] z_plane;
        logic       voxel_value;
    } t_cmd_in;

    typedef struct packed {
        logic               serial_bit;
        logic [LINES_W-1:0] plane_lines;
        logic               latch_after;
        logic               error_flag;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic exec;      // apply the accepted command to the store / scan counter
        logic load;      // load the frame shifter
        logic shift;     // advance the frame shifter
        logic emit_err;  // present an error result
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic err;
        logic show;
        logic last;
    } t_dp_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_ERR
    } t_state;

endpackage

// ===== hdl/led_cube_plane_multiplexer_top.sv =====
// led_cube_plane_multiplexer_top: top level of the LED cube plane multiplexer.
// Depends on lcpm_pkg, lcpm_controller and lcpm_datapath.
`timescale 1ns / 1ps

// Usage
// - Command channel: a transaction is taken at the clock edge where start is
//   high and busy is low. i_cmd carries func, x/y/z coordinates and the bit.
// - Results: one per clock while o_strobe is high; the receiver cannot stall,
//   so each result must be sampled in its strobe cycle.
// - Clear all, write voxel and fill plane complete at the accepting edge and
//   give no result; busy stays low, so another command may follow at once.
// - Show plane / show next plane: frame starts on the cycle after the accept
//   and carries 32 bits in mode 0 (plane one-hot field last) or 25 bits in
//   mode 1, MSB first, latch_after set on the final bit. The frame shifter
//   puts out one bit per clock, and busy stays high until the frame ends.
// - A checked coordinate of 5 or more (x/y/z for write, z for fill and show)
//   gives one error result, busy high, in the next cycle; the store is untouched.
// - Config: drive_mode is written on i_cfg_valid && o_cfg_ready; ready is
//   always high. Write it only while idle.
// - Reset (synchronous, active low) clears the voxel store, the scan counter
//   and drive_mode at once; no clearing sweep is needed.
module led_cube_plane_multiplexer_top
    import lcpm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    // command channel
    input  logic    start,
    output logic    busy,
    input  t_cmd_in i_cmd,
    // result channel
    output logic    o_strobe,
    output t_result o_result,
    // config write channel
    input  logic    i_cfg_valid,
    output logic    o_cfg_ready,
    input  logic    i_cfg_data
);

    t_dp_cmd    ctl;
    t_dp_status status;

    // config register lives in the datapath and is always writable
    assign o_cfg_ready = 1'b1;

    lcpm_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_ctl    (ctl),
        .o_strobe (o_strobe),
        .busy     (busy)
    );

    // store, scan counter and frame shifter
    lcpm_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_ctl       (ctl),
        .o_status    (status),
        .o_result    (o_result)
    );

endmodule

// ===== hdl/lcpm_datapath.sv =====
// lcpm_datapath: voxel store, scan counter, drive mode register and frame
// shifter. Depends on lcpm_pkg.
`timescale 1ns / 1ps

module lcpm_datapath
    import lcpm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd_in    i_cmd,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_data,
    input  t_dp_cmd    i_ctl,
    output t_dp_status o_status,
    output t_result    o_result
);

    logic [PLANE_BITS-1:0] r_voxel [CUBE_SIDE];
    logic [Z_W-1:0]        r_scan;
    logic                  r_mode;
    logic [FRAME_BITS-1:0] r_frame;
    logic [LINES_W-1:0]    r_lines;
    logic [CNT_W-1:0]      r_count;

    logic                  x_bad, y_bad, z_bad, err;
    logic [Z_W-1:0]        z_sel, show_z, scan_next;
    logic [POS_W-1:0]      pos;
    logic [PLANE_BITS-1:0] plane;
    logic [FRAME_BITS-1:0] frame;

    assign x_bad = i_cmd.x_row   >= COORD_W'(CUBE_SIDE);
    assign y_bad = i_cmd.y_col   >= COORD_W'(CUBE_SIDE);
    assign z_bad = i_cmd.z_plane >= COORD_W'(CUBE_SIDE);

    always_comb begin
        case (i_cmd.func)
            FUNC_WRITE: err = x_bad | y_bad | z_bad;
            FUNC_FILL:  err = z_bad;
            FUNC_SHOW:  err = z_bad;
            default:    err = 1'b0;
        endcase
    end

    assign z_sel     = i_cmd.z_plane[Z_W-1:0];
    assign pos       = POS_W'(i_cmd.y_col) + POS_W'(i_cmd.x_row) * POS_W'(CUBE_SIDE);
    assign show_z    = (i_cmd.func == FUNC_NEXT) ? r_scan : z_sel;
    assign scan_next = (r_scan == Z_W'(CUBE_SIDE - 1)) ? '0 : r_scan + 1'b1;
    assign plane     = r_voxel[show_z];

    always_comb begin
        if (r_mode) begin
            frame = {plane, {ALIGN_BITS{1'b0}}};
        end else begin
            frame = {{PAD_BITS{1'b0}}, plane, CUBE_SIDE'(1) << show_z};
        end
    end

    assign o_status.err  = err;
    assign o_status.show = ((i_cmd.func == FUNC_SHOW) && !z_bad) || (i_cmd.func == FUNC_NEXT);
    assign o_status.last = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CUBE_SIDE; i++) begin
                r_voxel[i] <= '0;
            end
            r_scan <= '0;
            r_mode <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            if (i_ctl.exec && !err) begin
                case (i_cmd.func)
                    FUNC_CLEAR: begin
                        for (int i = 0; i < CUBE_SIDE; i++) begin
                            r_voxel[i] <= '0;
                        end
                    end
                    FUNC_WRITE: r_voxel[z_sel][pos] <= i_cmd.voxel_value;
                    FUNC_FILL:  r_voxel[z_sel] <= '1;
                    FUNC_NEXT:  r_scan <= scan_next;
                    default: ;
                endcase
            end
        end
    end

    // frame shifter, MSB first
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_frame <= frame;
            r_lines <= r_mode ? (LINES_W'(1) << show_z) : '0;
            r_count <= r_mode ? CNT_W'(PLANE_BITS - 1) : CNT_W'(FRAME_BITS - 1);
        end else if (i_ctl.shift) begin
            r_frame <= {r_frame[FRAME_BITS-2:0], 1'b0};
            r_count <= r_count - 1'b1;
        end
    end

    always_comb begin
        if (i_ctl.emit_err) begin
            o_result = '{serial_bit: 1'b0, plane_lines: '0, latch_after: 1'b0,
                         error_flag: 1'b1};
        end else begin
            o_result = '{serial_bit: r_frame[FRAME_BITS-1], plane_lines: r_lines,
                         latch_after: o_status.last, error_flag: 1'b0};
        end
    end

endmodule

// ===== hdl/lcpm_controller.sv =====
// lcpm_controller: command sequencer for the plane multiplexer; issues
// datapath commands from status. Depends on lcpm_pkg.
`timescale 1ns / 1ps

module lcpm_controller
    import lcpm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  t_dp_status i_status,
    output t_dp_cmd    o_ctl,
    output logic       o_strobe,
    output logic       busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_ctl    = '0;
        o_strobe = 1'b0;
        busy     = 1'b1;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_ctl.exec = 1'b1;
                    if (i_status.err) begin
                        n_state = ST_ERR;
                    end else if (i_status.show) begin
                        o_ctl.load = 1'b1;
                        n_state    = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT: begin
                o_strobe    = 1'b1;
                o_ctl.shift = 1'b1;
                if (i_status.last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_ERR: begin
                o_strobe       = 1'b1;
                o_ctl.emit_err = 1'b1;
                n_state        = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ERR |=> r_state == ST_IDLE)
        else $error("error result held for more than one cycle");

    a_err_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_status.err) |=> (r_state == ST_ERR && o_strobe))
        else $error("bad coordinate did not give an error result");

    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHIFT && i_status.last) |=> !o_strobe && !busy)
        else $error("frame ran past its latch bit");

    a_show_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_status.err && i_status.show) |=> r_state == ST_SHIFT)
        else $error("show command did not start a frame");

endmodule

// ===== dv/led_cube_plane_multiplexer_top_tb.sv =====
// led_cube_plane_multiplexer_top_tb: self-checking testbench for the LED cube plane multiplexer.
// Depends on lcpm_pkg and led_cube_plane_multiplexer_top. A cycle-free cube model predicts
// every shifted bit, and each strobed result is checked in order against that prediction.
`timescale 1ns / 1ps

module led_cube_plane_multiplexer_top_tb;
    import lcpm_pkg::*;

    // Command codes 5 to 7 carry no operation; the block must drop them silently.
    localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
    localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;
    localparam int         CYCLE_LIMIT      = 200000;
    localparam int         TAIL_CYCLES      = 40;
    localparam int         DRAIN_CYCLES     = 4;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_cmd_in i_cmd;
    logic    o_strobe;
    t_result o_result;
    logic    i_cfg_valid;
    logic    o_cfg_ready;
    logic    i_cfg_data;

    // Cube model: one 25-bit word per plane, bit y + x*CUBE_SIDE.
    logic [PLANE_BITS-1:0] cube_store [CUBE_SIDE];
    int                    scan_ptr;
    logic                  mode_direct;

    // Shifted bits still owed by the block, oldest first.
    t_result shift_due_q[$];

    int   fail_count  = 0;
    int   cycle_count = 0;
    int   burst_left  = 0;
    bit   gaps_on     = 1'b1;

    led_cube_plane_multiplexer_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: a hung handshake or a lost frame ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $realtime, cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------- model

    function automatic t_cmd_in mk_cmd(logic [2:0] func, logic [2:0] x, logic [2:0] y,
                                       logic [2:0] z, logic v);
        t_cmd_in c;
        c.func        = func;
        c.x_row       = x;
        c.y_col       = y;
        c.z_plane     = z;
        c.voxel_value = v;
        return c;
    endfunction

    task automatic push_error_bit();
        t_result r;
        r = '0;
        r.error_flag = 1'b1;
        shift_due_q.push_back(r);
    endtask

    // Queue the frame for plane z, highest bit first, latch mark on the last bit.
    task automatic push_plane_frame(int z);
        logic [FRAME_BITS-1:0] frame;
        logic [LINES_W-1:0]    lines;
        int                    nbits;
        t_result               r;
        frame = '0;
        frame[PLANE_BITS-1:0] = cube_store[z];
        lines = '0;
        if (!mode_direct) begin
            // plane one-hot sits below the voxel field, pad bits on top
            frame = frame << CUBE_SIDE;
            frame[z] = 1'b1;
            nbits = FRAME_BITS;
        end else begin
            lines[z] = 1'b1;
            nbits = PLANE_BITS;
        end
        for (int k = 0; k < nbits; k++) begin
            r.serial_bit  = frame[nbits - 1 - k];
            r.plane_lines = lines;
            r.latch_after = (k == nbits - 1);
            r.error_flag  = 1'b0;
            shift_due_q.push_back(r);
        end
    endtask

    task automatic apply_cube_cmd(t_cmd_in c);
        int p;
        case (c.func)
            FUNC_CLEAR: begin
                foreach (cube_store[i]) cube_store[i] = '0;
            end
            FUNC_WRITE: begin
                if (c.x_row >= CUBE_SIDE || c.y_col >= CUBE_SIDE || c.z_plane >= CUBE_SIDE)
                    push_error_bit();
                else
                    cube_store[c.z_plane][c.y_col + c.x_row * CUBE_SIDE] = c.voxel_value;
            end
            FUNC_FILL: begin
                if (c.z_plane >= CUBE_SIDE)
                    push_error_bit();
                else
                    cube_store[c.z_plane] = '1;
            end
            FUNC_SHOW: begin
                if (c.z_plane >= CUBE_SIDE)
                    push_error_bit();
                else
                    push_plane_frame(c.z_plane);
            end
            FUNC_NEXT: begin
                p = (scan_ptr >= CUBE_SIDE) ? 0 : scan_ptr;
                scan_ptr = (p + 1 >= CUBE_SIDE) ? 0 : p + 1;
                push_plane_frame(p);
            end
            default: begin
            end
        endcase
    endtask

    // -------------------------------------------------------------- checker

    task automatic check_field(string name, int want, int got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, name, want, got);
        end
    endtask

    // The receiver has no back-pressure: every strobe is one transaction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (shift_due_q.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result, expected none actual %0h",
                         $realtime, o_result);
            end else begin
                check_field("serial_bit",  shift_due_q[0].serial_bit,  o_result.serial_bit);
                check_field("plane_lines", shift_due_q[0].plane_lines, o_result.plane_lines);
                check_field("latch_after", shift_due_q[0].latch_after, o_result.latch_after);
                check_field("error_flag",  shift_due_q[0].error_flag,  o_result.error_flag);
                void'(shift_due_q.pop_front());
            end
        end
    end

    // --------------------------------------------------------------- driver

    // Bursts of commands, separated by idle gaps while gaps_on is set; a long gap
    // now and then lets the next start land at any point of a running frame.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            if (gaps_on) begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
                repeat (gap) begin
                    @(negedge i_clk);
                    start = 1'b0;
                end
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
    endtask

    // One command transaction: start held high until busy is seen low at an edge.
    task automatic issue_cmd(t_cmd_in c);
        pace_sender();
        @(negedge i_clk);
        start = 1'b1;
        i_cmd = c;
        do @(posedge i_clk); while (busy);
        apply_cube_cmd(c);
    endtask

    // Idle the command side until every owed bit has come out, then a short pause.
    task automatic wait_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (shift_due_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_drive_mode(logic m);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = m;
        do @(posedge i_clk); while (!o_cfg_ready);
        mode_direct = m;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        i_cfg_data  = 1'($urandom_range(0, 1));
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_blank_cube();
        issue_cmd(mk_cmd(FUNC_SHOW, 3'd0, 3'd0, 3'd4, 1'b0));
        issue_cmd(mk_cmd(FUNC_NEXT, 3'd7, 3'd7, 3'd7, 1'b1));
    endtask

    task automatic test_voxel_corners();
        issue_cmd(mk_cmd(FUNC_WRITE, 3'd0, 3'd0, 3'd0, 1'b1));
        issue_cmd(mk_cmd(FUNC_WRITE, 3'd4, 3'd4, 3'd4, 1'b1));
        issue_cmd(mk_cmd(FUNC_WRITE, 3'd4, 3'd0, 3'd4, 1'b1));
        issue_cmd(mk_cmd(FUNC_SHOW,  3'd0, 3'd0, 3'd0, 1'b0));
        issue_cmd(mk_cmd(FUNC_SHOW,  3'd0, 3'd0, 3'd4, 1'b0));
        issue_cmd(mk_cmd(FUNC_WRITE, 3'd0, 3'd0, 3'd0, 1'b0));
        issue_cmd(mk_cmd(FUNC_SHOW,  3'd0, 3'd0, 3'd0, 1'b0));
    endtask

    task automatic test_fill_and_clear();
        issue_cmd(mk_cmd(FUNC_FILL,  3'd0, 3'd0, 3'd3, 1'b0));
        issue_cmd(mk_cmd(FUNC_SHOW,  3'd0, 3'd0, 3'd3, 1'b0));
        issue_cmd(mk_cmd(FUNC_CLEAR, 3'd0, 3'd0, 3'd0, 1'b0));
        issue_cmd(mk_cmd(FUNC_SHOW,  3'd0, 3'd0, 3'd3, 1'b0));
    endtask

    // Out-of-range coordinates: one error bit each and the store left alone.
    task automatic test_bad_coords();
        issue_cmd(mk_cmd(FUNC_WRITE, 3'd5, 3'd0, 3'd1, 1'b1));
        issue_cmd(mk_cmd(FUNC_WRITE, 3'd1, 3'd7, 3'd1, 1'b1));
        issue_cmd(mk_cmd(FUNC_WRITE, 3'd1, 3'd1, 3'd5, 1'b1));
        issue_cmd(mk_cmd(FUNC_FILL,  3'd0, 3'd0, 3'd7, 1'b0));
        issue_cmd(mk_cmd(FUNC_SHOW,  3'd0, 3'd0, 3'd6, 1'b0));
    endtask

    task automatic test_spare_codes();
        for (logic [3:0] f = FUNC_SPARE_FIRST; f <= FUNC_SPARE_LAST; f++)
            issue_cmd(mk_cmd(f[2:0], 3'd7, 3'd7, 3'd7, 1'b1));
    endtask

    // Direct plane drive, and the scan counter running past the top plane.
    task automatic test_scan_wrap_direct();
        set_drive_mode(1'b1);
        issue_cmd(mk_cmd(FUNC_WRITE, 3'd2, 3'd3, 3'd0, 1'b1));
        repeat (CUBE_SIDE) issue_cmd(mk_cmd(FUNC_NEXT, 3'd0, 3'd0, 3'd0, 1'b0));
        set_drive_mode(1'b0);
    endtask

    function automatic t_cmd_in rand_cmd();
        int sel;
        t_cmd_in c;
        sel = $urandom_range(0, 99);
        c = mk_cmd(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                   3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                   1'($urandom_range(0, 1)));
        if (sel < 45) begin
            c.func    = FUNC_WRITE;
            c.x_row   = 3'($urandom_range(0, CUBE_SIDE - 1));
            c.y_col   = 3'($urandom_range(0, CUBE_SIDE - 1));
            c.z_plane = 3'($urandom_range(0, CUBE_SIDE - 1));
        end else if (sel < 52) begin
            c.func = FUNC_WRITE;
        end else if (sel < 60) begin
            c.func = FUNC_FILL;
            if ($urandom_range(0, 2) != 0) c.z_plane = 3'($urandom_range(0, CUBE_SIDE - 1));
        end else if (sel < 76) begin
            c.func = FUNC_SHOW;
            if ($urandom_range(0, 4) != 0) c.z_plane = 3'($urandom_range(0, CUBE_SIDE - 1));
        end else if (sel < 91) begin
            c.func = FUNC_NEXT;
        end else if (sel < 94) begin
            c.func = FUNC_CLEAR;
        end else begin
            c.func = 3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
        end
        return c;
    endfunction

    // Four phases alternating the drive mode; one phase runs with no sender gaps.
    task automatic test_random_traffic(int items);
        t_cmd_in c;
        logic    first_mode;
        int      counted;
        first_mode = 1'($urandom_range(0, 1));
        for (int ph = 0; ph < 4; ph++) begin
            set_drive_mode(first_mode ^ ph[0]);
            gaps_on = (ph != 2);
            counted = 0;
            while (counted < items / 4) begin
                c = rand_cmd();
                issue_cmd(c);
                if (c.func <= FUNC_NEXT) counted++;
            end
        end
        gaps_on = 1'b1;
    endtask

    // ----------------------------------------------------------------- main

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cmd       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = 1'b0;
        foreach (cube_store[i]) cube_store[i] = '0;
        scan_ptr    = 0;
        mode_direct = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_blank_cube();
        test_voxel_corners();
        test_fill_and_clear();
        test_bad_coords();
        test_spare_codes();
        test_scan_wrap_direct();
        test_random_traffic(80);

        @(negedge i_clk);
        start = 1'b0;
        for (int i = 0; i < 4000 && shift_due_q.size() != 0; i++) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (shift_due_q.size() != 0) begin
            fail_count++;
            $display("%0t: results missing, expected %0d more actual 0",
                     $realtime, shift_due_q.size());
        end

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
